FILE: rtl/lru_page_replacement_macros.svh
// Assertion helpers shared by the RTL.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LRUPR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LRUPR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/lrupr_pkg.sv
package lrupr_pkg;

   localparam int unsigned PAGE_NUMBER_W     = 16;
   localparam int unsigned FAULT_TOTAL_W     = 32;
   localparam int unsigned FRAME_COUNT_W     = 4;
   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } fsm_state_type;

   // Broadcast from the controller to every frame cell
   typedef struct packed {
      logic update;   // apply this reference to the frames
      logic miss;     // page not resident
      logic fill;     // miss goes to the first free frame
      logic clear;    // last reference of the stream: drop all frames
   } cell_cmd_type;

endpackage

FILE: rtl/lrupr_cell.sv
module lrupr_cell
   import lrupr_pkg::*;
#(
   parameter int unsigned PAGE_BITS = 16,
   parameter int unsigned RANK_W    = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic [PAGE_BITS-1:0] page_key,
   input  logic [RANK_W-1:0]    old_rank,
   input  logic                 free_seen_in,
   output logic                 free_seen_out,
   input  logic                 hit_in,
   output logic                 hit_out,
   input  logic [RANK_W-1:0]    hit_rank_in,
   output logic [RANK_W-1:0]    hit_rank_out,
   output logic                 match
);

   logic                 valid_ff;
   logic [RANK_W-1:0]    rank_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 match_ff;
   logic                 match_in;
   logic                 first_free;
   logic                 victim;
   logic                 target;

   assign match_in      = valid_ff && (page_ff == page_key);
   assign first_free    = !valid_ff && !free_seen_in;
   assign victim        = valid_ff && (rank_ff == old_rank);
   assign target        = cmd.miss ? (cmd.fill ? first_free : victim) : match_ff;

   assign free_seen_out = free_seen_in | ~valid_ff;
   assign hit_out       = hit_in | match_ff;
   assign hit_rank_out  = hit_rank_in | (match_ff ? rank_ff : '0);
   assign match         = match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
         if (cmd.update) begin
            if (cmd.clear) begin
               valid_ff <= 1'b0;
               rank_ff  <= '0;
            end else if (target) begin
               valid_ff <= 1'b1;
               rank_ff  <= '0;
            end else if (valid_ff && (rank_ff < old_rank)) begin
               rank_ff <= rank_ff + RANK_W'(1);
            end
         end
      end
   end

   // page storage has no reset; only read behind valid
   always_ff @(posedge clock) begin
      if (cmd.update && !cmd.clear && cmd.miss && target) begin
         page_ff <= page_key;
      end
   end

endmodule

FILE: rtl/lrupr_frame_row.sv
module lrupr_frame_row
   import lrupr_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = 8,
   parameter int unsigned PAGE_BITS  = 16,
   parameter int unsigned RANK_W     = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [PAGE_BITS-1:0]  page_key,
   input  logic [RANK_W-1:0]     old_rank,
   output logic                  hit,
   output logic [RANK_W-1:0]     hit_rank,
   output logic [MAX_FRAMES-1:0] match_vec
);

   logic              free_chain [MAX_FRAMES+1];
   logic              hit_chain  [MAX_FRAMES+1];
   logic [RANK_W-1:0] rank_chain [MAX_FRAMES+1];

   assign free_chain[0] = 1'b0;
   assign hit_chain[0]  = 1'b0;
   assign rank_chain[0] = '0;

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .RANK_W    (RANK_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .page_key      (page_key),
         .old_rank      (old_rank),
         .free_seen_in  (free_chain[i]),
         .free_seen_out (free_chain[i+1]),
         .hit_in        (hit_chain[i]),
         .hit_out       (hit_chain[i+1]),
         .hit_rank_in   (rank_chain[i]),
         .hit_rank_out  (rank_chain[i+1]),
         .match         (match_vec[i])
      );
   end

   assign hit      = hit_chain[MAX_FRAMES];
   assign hit_rank = rank_chain[MAX_FRAMES];

endmodule

FILE: rtl/lru_page_replacement.sv
// LRU page replacement: one page reference per transaction, one result per
// reference (fault flag, saturating fault total of the stream, end flag).
// The frames sit in a row of cells, each holding one page, its valid bit and
// its recency rank. A reference runs through a look state, where every cell
// compares the page in parallel, then an update state, where the row applies
// the hit, fill or replacement and ages the other ranks. The next reference is
// taken in the update cycle, while the previous one is being applied.
// The update waits while the previous result is still held by rsp_stall.
// csr_frame_count sets the frames in use (0 acts as 1, above MAX_FRAMES acts
// as MAX_FRAMES); write it only while the block is idle. After the reference
// flagged end_of_stream all frames and the fault total are cleared. No
// clearing pass after reset.
`include "lru_page_replacement_macros.svh"

module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = 8,
   parameter int unsigned PAGE_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PAGE_NUMBER_W-1:0] req_page_number,
   input  logic                     req_end_of_stream,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_page_fault,
   output logic [FAULT_TOTAL_W-1:0] rsp_fault_total,
   output logic                     rsp_stream_done,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [FRAME_COUNT_W-1:0] csr_frame_count
);

   localparam int unsigned RANK_W = $clog2(MAX_FRAMES + 1);

   fsm_state_type            state_ff, state_in;
   logic [FRAME_COUNT_W-1:0] frame_count_ff;
   logic [PAGE_BITS-1:0]     page_key;
   logic [PAGE_BITS-1:0]     page_ff;
   logic                     end_ff;
   logic [RANK_W-1:0]        occupied_ff;
   logic [FAULT_TOTAL_W-1:0] fault_counter_ff, fault_counter_in;
   logic                     rsp_valid_ff;
   logic                     rsp_page_fault_ff;
   logic [FAULT_TOTAL_W-1:0] rsp_fault_total_ff;
   logic                     rsp_stream_done_ff;

   logic                     req_accept;
   logic                     out_free;
   logic                     do_update;
   logic [RANK_W-1:0]        limit;
   logic                     hit;
   logic [RANK_W-1:0]        hit_rank;
   logic [RANK_W-1:0]        old_rank;
   logic                     fill;
   logic [MAX_FRAMES-1:0]    match_vec;
   cell_cmd_type             cmd;

   if (PAGE_BITS <= PAGE_NUMBER_W) begin : g_key_trunc
      assign page_key = req_page_number[PAGE_BITS-1:0];
   end else begin : g_key_ext
      assign page_key = {{(PAGE_BITS-PAGE_NUMBER_W){1'b0}}, req_page_number};
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         frame_count_ff <= csr_frame_count;
      end
   end

   always_comb begin
      priority if (32'(frame_count_ff) > 32'(MAX_FRAMES)) begin
         limit = RANK_W'(MAX_FRAMES);
      end else if (frame_count_ff == '0) begin
         limit = RANK_W'(1);
      end else begin
         limit = RANK_W'(frame_count_ff);
      end
   end

   // sequencer
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = req_accept ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      do_update = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_LOOK: begin
            req_stall = 1'b1;
         end
         ST_UPDATE: begin
            req_stall = !out_free;
            do_update = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         page_ff <= page_key;
         end_ff  <= req_end_of_stream;
      end
   end

   // frame row
   assign fill     = occupied_ff < limit;
   // hit: frames more recent than the hit frame (lower rank) age; fill: every resident ages;
   // replace: the oldest frame (rank occupied-1) is reused
   assign old_rank = hit ? hit_rank : (fill ? occupied_ff : occupied_ff - RANK_W'(1));

   assign cmd.update = do_update;
   assign cmd.miss   = !hit;
   assign cmd.fill   = fill;
   assign cmd.clear  = end_ff;

   lrupr_frame_row #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .RANK_W     (RANK_W)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .page_key  (page_ff),
      .old_rank  (old_rank),
      .hit       (hit),
      .hit_rank  (hit_rank),
      .match_vec (match_vec)
   );

   // fault count and occupancy
   assign fault_counter_in = (!hit && (fault_counter_ff != '1))
                             ? fault_counter_ff + FAULT_TOTAL_W'(1)
                             : fault_counter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_counter_ff <= '0;
         occupied_ff      <= '0;
      end else if (do_update) begin
         if (end_ff) begin
            fault_counter_ff <= '0;
            occupied_ff      <= '0;
         end else begin
            fault_counter_ff <= fault_counter_in;
            if (!hit && fill) occupied_ff <= occupied_ff + RANK_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_update) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_update) begin
         rsp_page_fault_ff  <= !hit;
         rsp_fault_total_ff <= fault_counter_in;
         rsp_stream_done_ff <= end_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_page_fault  = rsp_page_fault_ff;
   assign rsp_fault_total = rsp_fault_total_ff;
   assign rsp_stream_done = rsp_stream_done_ff;

   `LRUPR_ASSERT(a_occupied_range, occupied_ff <= RANK_W'(MAX_FRAMES), "occupancy past capacity")
   `LRUPR_ASSERT(a_page_unique, $onehot0(match_vec), "page resident in two frames")
   `LRUPR_ASSERT(a_stream_clear, do_update && end_ff |=> occupied_ff == '0 && fault_counter_ff == '0, "stream end did not clear")
   `LRUPR_ASSERT(a_rsp_from_update, $rose(rsp_valid_ff) |-> $past(do_update), "result without update")
   `LRUPR_ASSERT(a_count_monotonic, do_update && !end_ff |=> fault_counter_ff >= $past(fault_counter_ff), "fault total went down")

endmodule
